// ----- hdl/urpa_pkg.sv -----
package urpa_pkg;

    // default sizes
    localparam int FIFO_DEPTH_DEF = 128;
    localparam int PACKET_MAX_DEF = 64;

    // fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int THRESH_W = 7;
    localparam int TOUT_W   = 8;
    localparam int WAIT_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [THRESH_W-1:0] SEND_THRESHOLD_RST = 7'd32;
    localparam logic [TOUT_W-1:0]   IDLE_TIMEOUT_RST   = 8'd20;
    localparam logic [WAIT_W-1:0]   WAIT_MAX           = 8'd255;

    // item kinds
    localparam logic [1:0] FUNC_PUT  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_DONE = 2'd2;

    // result kinds
    localparam logic KIND_PUT_ANSWER = 1'b0;
    localparam logic KIND_PKT_BYTE   = 1'b1;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEND_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 1'd1;

    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [BYTE_W-1:0] tx_byte;
        logic [LEN_W-1:0]  packet_len;
        logic              last;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic put;
        logic wait_inc;
        logic start_send;
        logic rd_issue;
        logic emit;
        logic clear_busy;
    } cmd_t;

    typedef struct packed {
        logic fifo_empty;
        logic busy;
        logic send_ok;
        logic last_byte;
        logic out_full;
    } status_t;

endpackage

// ----- hdl/urpa_ram.sv -----
module urpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/urpa_ctrl.sv -----
module urpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_func,
    input  logic                out_stall,
    input  urpa_pkg::status_t   status,
    output logic                in_stall,
    output urpa_pkg::cmd_t      cmd
);

    urpa_pkg::state_t state_reg;
    urpa_pkg::state_t state_next;

    logic out_free;
    logic in_fire;

    // output slot is free when empty or being taken this cycle
    assign out_free = !status.out_full || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        in_stall       = 1'b1;
        in_fire        = 1'b0;
        cmd            = '0;
        case (state_reg)
            urpa_pkg::ST_IDLE:
            begin
                in_stall = !out_free;
                in_fire  = in_valid && out_free;
                cmd.put        = in_fire && (in_func == urpa_pkg::FUNC_PUT);
                cmd.clear_busy = in_fire && (in_func == urpa_pkg::FUNC_DONE);
                if (in_fire && (in_func == urpa_pkg::FUNC_TICK) &&
                    !status.fifo_empty && !status.busy)
                begin
                    cmd.start_send = status.send_ok;
                    cmd.wait_inc   = !status.send_ok;
                end
            end
            urpa_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
            end
            urpa_pkg::ST_EMIT:
            begin
                cmd.emit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urpa_pkg::ST_IDLE:
            begin
                if (cmd.start_send)
                begin
                    state_next = urpa_pkg::ST_READ;
                end
            end
            urpa_pkg::ST_READ:
            begin
                state_next = urpa_pkg::ST_EMIT;
            end
            urpa_pkg::ST_EMIT:
            begin
                if (cmd.emit)
                begin
                    state_next = status.last_byte ? urpa_pkg::ST_IDLE : urpa_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = urpa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/urpa_dp.sv -----
module urpa_dp #(
    parameter int FIFO_DEPTH = urpa_pkg::FIFO_DEPTH_DEF,
    parameter int PACKET_MAX = urpa_pkg::PACKET_MAX_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  urpa_pkg::in_word_t                    in_data,
    input  logic                                  out_stall,
    input  logic                                  cfg_we,
    input  logic [urpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [urpa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  urpa_pkg::cmd_t                        cmd,
    output urpa_pkg::status_t                     status,
    output logic                                  out_valid,
    output urpa_pkg::out_word_t                   out_data
);

    localparam int AW   = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int CMPW = (CW > urpa_pkg::LEN_W) ? CW : urpa_pkg::LEN_W;
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(FIFO_DEPTH);

    logic [AW-1:0]                    wptr_reg, wptr_next;
    logic [AW-1:0]                    rptr_reg, rptr_next;
    logic [CW-1:0]                    fill_reg, fill_next;
    logic                             busy_reg, busy_next;
    logic [urpa_pkg::WAIT_W-1:0]      wait_reg, wait_next;
    logic [urpa_pkg::THRESH_W-1:0]    thresh_reg, thresh_next;
    logic [urpa_pkg::TOUT_W-1:0]      tout_reg, tout_next;
    logic [urpa_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [urpa_pkg::LEN_W-1:0]       remain_reg, remain_next;
    logic                             out_valid_reg, out_valid_next;
    urpa_pkg::out_word_t              out_data_reg, out_data_next;

    logic                             fifo_full;
    logic                             do_write;
    logic [CMPW-1:0]                  fill_ext;
    logic [urpa_pkg::LEN_W-1:0]       send_len;
    logic [urpa_pkg::BYTE_W-1:0]      rd_byte;

    assign fifo_full = (fill_reg == FILL_FULL);
    assign do_write  = cmd.put && !fifo_full;
    assign fill_ext  = CMPW'(fill_reg);
    assign send_len  = (fill_ext >= CMPW'(PACKET_MAX)) ? urpa_pkg::LEN_W'(PACKET_MAX)
                                                       : urpa_pkg::LEN_W'(fill_ext);

    urpa_ram #(
        .WIDTH (urpa_pkg::BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (do_write),
        .waddr (wptr_reg),
        .wdata (in_data.rx_byte),
        .re    (cmd.rd_issue),
        .raddr (rptr_reg),
        .rdata (rd_byte)
    );

    always_comb
    begin
        status.fifo_empty = (fill_reg == '0);
        status.busy       = busy_reg;
        status.send_ok    = (wait_reg > tout_reg) || (fill_ext >= CMPW'(thresh_reg));
        status.last_byte  = (remain_reg == urpa_pkg::LEN_W'(1));
        status.out_full   = out_valid_reg;
    end

    always_comb
    begin
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        fill_next      = fill_reg;
        busy_next      = busy_reg;
        wait_next      = wait_reg;
        thresh_next    = thresh_reg;
        tout_next      = tout_reg;
        len_next       = len_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                urpa_pkg::REG_SEND_THRESHOLD:
                    thresh_next = cfg_data[urpa_pkg::THRESH_W-1:0];
                urpa_pkg::REG_IDLE_TIMEOUT:
                    tout_next = cfg_data[urpa_pkg::TOUT_W-1:0];
                default:
                    thresh_next = thresh_reg;
            endcase
        end

        if (cmd.put)
        begin
            out_valid_next          = 1'b1;
            out_data_next           = '0;
            out_data_next.kind      = urpa_pkg::KIND_PUT_ANSWER;
            out_data_next.accepted  = !fifo_full;
            if (!fifo_full)
            begin
                wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + AW'(1);
                fill_next = fill_reg + CW'(1);
            end
        end

        if (cmd.wait_inc && (wait_reg != urpa_pkg::WAIT_MAX))
        begin
            wait_next = wait_reg + urpa_pkg::WAIT_W'(1);
        end

        if (cmd.start_send)
        begin
            len_next    = send_len;
            remain_next = send_len;
            busy_next   = 1'b1;
            wait_next   = '0;
        end

        if (cmd.emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.kind       = urpa_pkg::KIND_PKT_BYTE;
            out_data_next.accepted   = 1'b0;
            out_data_next.tx_byte    = rd_byte;
            out_data_next.packet_len = len_reg;
            out_data_next.last       = status.last_byte;
            rptr_next   = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + AW'(1);
            fill_next   = fill_reg - CW'(1);
            remain_next = remain_reg - urpa_pkg::LEN_W'(1);
        end

        if (cmd.clear_busy)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            wait_reg      <= '0;
            thresh_reg    <= urpa_pkg::SEND_THRESHOLD_RST;
            tout_reg      <= urpa_pkg::IDLE_TIMEOUT_RST;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            thresh_reg    <= thresh_next;
            tout_reg      <= tout_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count above depth");

    a_send_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_send |-> (fill_reg != '0) && !busy_reg)
        else $error("packet started from empty fifo or while busy");

    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (remain_reg != '0) && (fill_reg != '0))
        else $error("byte emitted with nothing left");

    a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.last_byte) |=> busy_reg && out_valid_reg && out_data_reg.last)
        else $error("packet end without busy flag or last marker");

endmodule

// ----- hdl/uart_rx_packet_aggregator.sv -----
// channel   | valid      | stall      | payload
// ----------+------------+------------+-------------------------------
// input     | in_valid   | in_stall   | in_data  (func, rx_byte)
// output    | out_valid  | out_stall  | out_data (kind, accepted,
//           |            |            |   tx_byte, packet_len, last)
// config    | cfg_we     | -          | cfg_index, cfg_data
//
// input words are taken only in the idle state; a tick that sends a packet
// steps through one ram read and one output load per byte.
// a new word is taken while the previous result sits in the output register,
// as long as that register is empty or drained in the same cycle.
// out_stall holds the output register and backs up into in_stall.
// rst_n clears pointers, counts, busy flag and loads the register defaults;
// the fifo ram has no reset and needs no clearing pass.
module uart_rx_packet_aggregator #(
    parameter int FIFO_DEPTH = urpa_pkg::FIFO_DEPTH_DEF,
    parameter int PACKET_MAX = urpa_pkg::PACKET_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  urpa_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output urpa_pkg::out_word_t              out_data,
    input  logic                             cfg_we,
    input  logic [urpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [urpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    urpa_pkg::cmd_t    cmd;
    urpa_pkg::status_t status;

    urpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_func   (in_data.func),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    urpa_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .PACKET_MAX (PACKET_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
